// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and ignored during reset.
`define CHK_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: ante implies cons in the same cycle");

// Next-cycle implication, sampled on the rising clock edge and ignored during reset.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: ante implies cons in the next cycle");

`endif

// ===== sv/shhp_pkg.sv =====
package shhp_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int COST_W    = 7;
    localparam int DIST_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int HOP_ROW_W = MAX_NODES + MAX_NODES * DIST_W;
    localparam int BEST_AW   = MAX_NODES + NODE_W;

    localparam logic [COST_W-1:0] COST_CAP = 7'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_NODE  = 2'd2;

    localparam logic FUNC_EDGE  = 1'b0;
    localparam logic FUNC_SOLVE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BFS,
        S_INIT,
        S_MASK,
        S_CUR,
        S_RD,
        S_ACC,
        S_WR,
        S_ANSW,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic edge_wr;
        logic res_cap;
        logic bfs_init;
        logic bfs_step;
        logic init_wr;
        logic mask_start;
        logic mask_dec;
        logic cur_inc;
        logic row_rd;
        logic cand_rd;
        logic acc;
        logic best_wr;
        logic ans_rd;
        logic res_load;
        logic out_load;
        logic adj_clear;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic bfs_done;
        logic cur_last;
        logic i_last;
        logic mask_zero;
        logic mask_has_start;
        logic cur_in_mask;
    } sts_t;

endpackage

// ===== sv/shortest_hamiltonian_hop_path_unit.sv =====
// Shortest Hamiltonian hop path unit.
// Input channel (in_valid/in_ready): each request carries func, node_a and node_b.
// An edge request (func 0) sets the undirected edge node_a-node_b and leaves the
// input ready, so edge requests may arrive back to back. A solve request (func 1)
// runs a breadth-first search from every node, then a Held-Karp sweep, and
// returns one min_cost on the output channel (out_valid/out_ready); 100 means
// no route. After the answer the adjacency matrix is cleared.
// Configuration (cfg_valid/cfg_ready, always ready) writes node_count, start_node
// and dest_node by index 0, 1 and 2; the sender must write them only while the
// unit is idle, which the unit itself does not enforce. A solve runs a search per
// source node, writes one cost-table entry per node, then for every mask holding
// the start node sweeps each current node in it, reading the single-port cost
// table once per candidate. With an invalid configuration the search and sweep
// are skipped; the capped answer is registered, then loaded into the output.
// The input stays stalled from a solve request until its answer is loaded into
// the output register; a stalled receiver holds min_cost and out_valid steady.
// Reset clears the adjacency matrix and restores node_count 1 and nodes 0.
module shortest_hamiltonian_hop_path_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [shhp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [shhp_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic [shhp_pkg::NODE_W-1:0]      node_a,
    input  logic [shhp_pkg::NODE_W-1:0]      node_b,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [shhp_pkg::COST_W-1:0]      min_cost
);

    shhp_pkg::cmd_t cmd;
    shhp_pkg::sts_t sts;

    // Taken unchecked; the sender must issue configuration writes only while idle.
    assign cfg_ready = 1'b1;

    shhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    shhp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .node_a    (node_a),
        .node_b    (node_b),
        .cmd       (cmd),
        .sts       (sts),
        .min_cost  (min_cost)
    );

endmodule

// ===== sv/shhp_ctrl.sv =====
module shhp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            func,
    input  logic            out_ready,
    output logic            out_valid,
    input  shhp_pkg::sts_t  sts,
    output shhp_pkg::cmd_t  cmd
);

    shhp_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shhp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            shhp_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (func == shhp_pkg::FUNC_EDGE)
                    begin
                        cmd.edge_wr = 1'b1;
                    end
                    else if (sts.bad)
                    begin
                        cmd.res_cap = 1'b1;
                        state_next  = shhp_pkg::S_FINISH;
                    end
                    else
                    begin
                        cmd.bfs_init = 1'b1;
                        state_next   = shhp_pkg::S_BFS;
                    end
                end
            end
            shhp_pkg::S_BFS:
            begin
                cmd.bfs_step = 1'b1;
                if (sts.bfs_done)
                begin
                    state_next = shhp_pkg::S_INIT;
                end
            end
            shhp_pkg::S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.cur_last)
                begin
                    cmd.mask_start = 1'b1;
                    state_next     = shhp_pkg::S_MASK;
                end
            end
            shhp_pkg::S_MASK:
            begin
                if (sts.mask_zero)
                begin
                    cmd.ans_rd = 1'b1;
                    state_next = shhp_pkg::S_ANSW;
                end
                else if (!sts.mask_has_start)
                begin
                    cmd.mask_dec = 1'b1;
                end
                else
                begin
                    state_next = shhp_pkg::S_CUR;
                end
            end
            shhp_pkg::S_CUR:
            begin
                if (sts.cur_in_mask)
                begin
                    cmd.row_rd = 1'b1;
                    state_next = shhp_pkg::S_RD;
                end
                else if (sts.cur_last)
                begin
                    cmd.mask_dec = 1'b1;
                    state_next   = shhp_pkg::S_MASK;
                end
                else
                begin
                    cmd.cur_inc = 1'b1;
                end
            end
            shhp_pkg::S_RD:
            begin
                cmd.cand_rd = 1'b1;
                state_next  = shhp_pkg::S_ACC;
            end
            shhp_pkg::S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.i_last ? shhp_pkg::S_WR : shhp_pkg::S_RD;
            end
            shhp_pkg::S_WR:
            begin
                cmd.best_wr = 1'b1;
                if (sts.cur_last)
                begin
                    cmd.mask_dec = 1'b1;
                    state_next   = shhp_pkg::S_MASK;
                end
                else
                begin
                    cmd.cur_inc = 1'b1;
                    state_next  = shhp_pkg::S_CUR;
                end
            end
            shhp_pkg::S_ANSW:
            begin
                cmd.res_load = 1'b1;
                state_next   = shhp_pkg::S_FINISH;
            end
            shhp_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.adj_clear = 1'b1;
                    state_next    = shhp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = shhp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/shhp_dpath.sv =====
module shhp_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr,
    input  logic [shhp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [shhp_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic [shhp_pkg::NODE_W-1:0]        node_a,
    input  logic [shhp_pkg::NODE_W-1:0]        node_b,
    input  shhp_pkg::cmd_t                     cmd,
    output shhp_pkg::sts_t                     sts,
    output logic [shhp_pkg::COST_W-1:0]        min_cost
);

    localparam int N  = shhp_pkg::MAX_NODES;
    localparam int NW = shhp_pkg::NODE_W;
    localparam int CW = shhp_pkg::COUNT_W;
    localparam int DW = shhp_pkg::DIST_W;
    localparam int KW = shhp_pkg::COST_W;

    // Configuration and adjacency.
    logic [CW-1:0]  node_count_reg;
    logic [NW-1:0]  start_reg;
    logic [NW-1:0]  dest_reg;
    logic [N-1:0]   adj_reg [N];
    logic [N-1:0]   adj_next [N];

    // Search and sweep control.
    logic [NW-1:0]  src_reg, src_next;
    logic [N-1:0]   visited_reg, visited_next;
    logic [N-1:0]   frontier_reg, frontier_next;
    logic [DW-1:0]  level_reg, level_next;
    logic [N-1:0]   m_reg, m_next;
    logic [NW-1:0]  cur_reg, cur_next;
    logic [NW-1:0]  i_reg, i_next;

    // Payload.
    logic [N-1:0][DW-1:0] dist_row_reg, dist_row_next;
    logic [KW-1:0]  best_reg, best_next;
    logic           cand_ok_reg;
    logic [DW-1:0]  cand_dist_reg;
    logic [KW-1:0]  res_reg;
    logic [KW-1:0]  min_cost_reg;

    // Memories.
    logic [shhp_pkg::HOP_ROW_W-1:0] hop_mem [N];
    logic [shhp_pkg::HOP_ROW_W-1:0] hop_rdata;
    logic [KW-1:0]  best_mem [2**shhp_pkg::BEST_AW];
    logic [KW-1:0]  best_rdata;

    logic [CW-1:0]  n_eff;
    logic [CW-1:0]  last_idx;
    logic [N-1:0]   full_mask;
    logic [N-1:0]   nxt;
    logic [N-1:0]   hop_valid;
    logic [DW-1:0]  dist_i;
    logic [KW:0]    cand_sum;
    logic           best_we;
    logic [shhp_pkg::BEST_AW-1:0] best_waddr;
    logic [shhp_pkg::BEST_AW-1:0] best_raddr;
    logic [KW-1:0]  best_wdata;
    logic           best_re;

    assign n_eff     = (node_count_reg > CW'(N)) ? CW'(N) : node_count_reg;
    assign last_idx  = n_eff - CW'(1);
    assign full_mask = ~({N{1'b1}} << n_eff);

    always_comb
    begin
        nxt = '0;
        for (int v = 0; v < N; v++)
        begin
            if (frontier_reg[v])
            begin
                nxt = nxt | adj_reg[v];
            end
        end
        nxt = nxt & ~visited_reg;
    end

    // Next adjacency rows: an edge sets both mirrored bits, a clear wipes all rows.
    always_comb
    begin
        for (int r = 0; r < N; r++)
        begin
            adj_next[r] = adj_reg[r];
            if (cmd.adj_clear)
            begin
                adj_next[r] = '0;
            end
            else if (cmd.edge_wr)
            begin
                if (NW'(r) == node_a)
                begin
                    adj_next[r][node_b] = 1'b1;
                end
                if (NW'(r) == node_b)
                begin
                    adj_next[r][node_a] = 1'b1;
                end
            end
        end
    end

    assign hop_valid = hop_rdata[shhp_pkg::HOP_ROW_W-1 -: N];
    assign dist_i    = hop_rdata[DW*i_reg +: DW];
    assign cand_sum  = {1'b0, best_rdata} + (KW+1)'(cand_dist_reg);

    assign sts.bad            = (n_eff == '0) || ({1'b0, start_reg} >= n_eff)
                                || ({1'b0, dest_reg} >= n_eff);
    assign sts.bfs_done       = (nxt == '0) && ({1'b0, src_reg} == last_idx);
    assign sts.cur_last       = ({1'b0, cur_reg} == last_idx);
    assign sts.i_last         = ({1'b0, i_reg} == last_idx);
    assign sts.mask_zero      = (m_reg == '0);
    assign sts.mask_has_start = m_reg[start_reg];
    assign sts.cur_in_mask    = m_reg[cur_reg];

    always_comb
    begin
        src_next      = src_reg;
        visited_next  = visited_reg;
        frontier_next = frontier_reg;
        level_next    = level_reg;
        dist_row_next = dist_row_reg;
        m_next        = m_reg;
        cur_next      = cur_reg;
        i_next        = i_reg;
        best_next     = best_reg;

        if (cmd.bfs_init)
        begin
            src_next          = '0;
            visited_next      = N'(1);
            frontier_next     = N'(1);
            level_next        = '0;
            dist_row_next[0]  = '0;
            cur_next          = '0;
        end

        if (cmd.bfs_step)
        begin
            if (nxt == '0)
            begin
                if (!sts.bfs_done)
                begin
                    src_next                = src_reg + NW'(1);
                    visited_next            = N'(1) << (src_reg + NW'(1));
                    frontier_next           = N'(1) << (src_reg + NW'(1));
                    level_next              = '0;
                    dist_row_next[src_next] = '0;
                end
            end
            else
            begin
                visited_next  = visited_reg | nxt;
                frontier_next = nxt;
                level_next    = level_reg + DW'(1);
                for (int v = 0; v < N; v++)
                begin
                    if (nxt[v])
                    begin
                        dist_row_next[v] = level_reg + DW'(1);
                    end
                end
            end
        end

        if (cmd.init_wr || cmd.cur_inc)
        begin
            cur_next = cur_reg + NW'(1);
        end

        if (cmd.mask_start)
        begin
            m_next   = full_mask - N'(1);
            cur_next = '0;
        end

        if (cmd.mask_dec)
        begin
            m_next   = m_reg - N'(1);
            cur_next = '0;
        end

        if (cmd.row_rd)
        begin
            i_next    = '0;
            best_next = shhp_pkg::COST_CAP;
        end

        if (cmd.acc)
        begin
            i_next = i_reg + NW'(1);
            if (cand_ok_reg && (cand_sum < {1'b0, best_reg}))
            begin
                best_next = cand_sum[KW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CW'(1);
            start_reg      <= '0;
            dest_reg       <= '0;
            for (int r = 0; r < N; r++)
            begin
                adj_reg[r] <= '0;
            end
            src_reg      <= '0;
            visited_reg  <= '0;
            frontier_reg <= '0;
            level_reg    <= '0;
            m_reg        <= '0;
            cur_reg      <= '0;
            i_reg        <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    shhp_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_data;
                    shhp_pkg::CFG_START_NODE: start_reg      <= cfg_data[NW-1:0];
                    shhp_pkg::CFG_DEST_NODE:  dest_reg       <= cfg_data[NW-1:0];
                    default:                  ;
                endcase
            end
            for (int r = 0; r < N; r++)
            begin
                adj_reg[r] <= adj_next[r];
            end
            src_reg      <= src_next;
            visited_reg  <= visited_next;
            frontier_reg <= frontier_next;
            level_reg    <= level_next;
            m_reg        <= m_next;
            cur_reg      <= cur_next;
            i_reg        <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_row_reg <= dist_row_next;
        best_reg     <= best_next;
        if (cmd.cand_rd)
        begin
            cand_ok_reg   <= !m_reg[i_reg] && hop_valid[i_reg];
            cand_dist_reg <= dist_i;
        end
        if (cmd.res_cap)
        begin
            res_reg <= shhp_pkg::COST_CAP;
        end
        else if (cmd.res_load)
        begin
            res_reg <= best_rdata;
        end
        if (cmd.out_load)
        begin
            min_cost_reg <= res_reg;
        end
    end

    // Hop distance rows: one row per source, written when its search ends.
    always_ff @(posedge clk)
    begin
        if (cmd.bfs_step && (nxt == '0))
        begin
            hop_mem[src_reg] <= {visited_reg, dist_row_reg};
        end
        if (cmd.row_rd)
        begin
            hop_rdata <= hop_mem[cur_reg];
        end
    end

    // Cost-to-finish table, addressed by {visited mask, current node}.
    assign best_we    = cmd.init_wr || cmd.best_wr;
    assign best_waddr = cmd.init_wr ? {full_mask, cur_reg} : {m_reg, cur_reg};
    assign best_wdata = cmd.init_wr ? ((cur_reg == dest_reg) ? '0 : shhp_pkg::COST_CAP)
                                    : best_reg;
    assign best_re    = cmd.cand_rd || cmd.ans_rd;
    assign best_raddr = cmd.ans_rd ? {N'(1) << start_reg, start_reg}
                                   : {m_reg | (N'(1) << i_reg), i_reg};

    always_ff @(posedge clk)
    begin
        if (best_we)
        begin
            best_mem[best_waddr] <= best_wdata;
        end
        if (best_re)
        begin
            best_rdata <= best_mem[best_raddr];
        end
    end

    assign min_cost = min_cost_reg;

endmodule

// ===== sv/shhp_checker.sv =====
`include "assert_macros.svh"

module shhp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             func,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [shhp_pkg::COST_W-1:0]      min_cost
);

    // A stalled result holds.
    `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(min_cost))

    // Costs saturate at the cap.
    `CHK_IMPLIES(a_cost_cap, out_valid, min_cost <= shhp_pkg::COST_CAP)

    // A solve request stalls the input for at least the next cycle.
    `CHK_NEXT(a_solve_stall, in_valid && in_ready && (func == shhp_pkg::FUNC_SOLVE), !in_ready)

    // Edge requests leave the input open for the next one.
    `CHK_NEXT(a_edge_open, in_valid && in_ready && (func == shhp_pkg::FUNC_EDGE), in_ready)

endmodule

bind shortest_hamiltonian_hop_path_unit shhp_checker u_shhp_checker (.*);
